FILE: rtl/lru_ts_pkg.sv
package lru_ts_pkg;

  localparam int REQ_TYPE_W  = 1;
  localparam int SET_INDEX_W = 6;
  localparam int TAG_VALUE_W = 12;
  localparam int SET_SPAN    = 2 ** SET_INDEX_W;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 16;

  localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 1'b1;

  typedef struct packed {
    logic [TAG_VALUE_W-1:0] victim_tag;
    logic                   writeback;
    logic                   hit;
  } result_t;

endpackage

FILE: rtl/lru_ts_mem.sv
module lru_ts_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 112
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lru_ts_update.sv
module lru_ts_update #(
  parameter int NUM_WAYS = 8,
  parameter int TAG_BITS = 12
) (
  input  logic [NUM_WAYS*(TAG_BITS+2)-1:0] row,
  input  logic                             is_write,
  input  logic [TAG_BITS-1:0]              tag,
  output logic [NUM_WAYS*(TAG_BITS+2)-1:0] new_row,
  output lru_ts_pkg::result_t              res
);
  import lru_ts_pkg::*;

  localparam int ENTRY_W = TAG_BITS + 2;
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int DIRTY_B = TAG_BITS;
  localparam int VALID_B = TAG_BITS + 1;

  logic [ENTRY_W-1:0]     ent [NUM_WAYS];
  logic [NUM_WAYS-1:0]    match;
  logic [TAG_VALUE_W-1:0] victim_tag12;

  for (genvar g = 0; g < NUM_WAYS; g++) begin : g_unpack
    assign ent[g]   = row[g*ENTRY_W +: ENTRY_W];
    assign match[g] = ent[g][VALID_B] && (ent[g][TAG_BITS-1:0] == tag);
  end

  if (TAG_BITS >= TAG_VALUE_W) begin : g_wide_tag
    assign victim_tag12 = ent[0][TAG_VALUE_W-1:0];
  end else begin : g_narrow_tag
    assign victim_tag12 = TAG_VALUE_W'(ent[0][TAG_BITS-1:0]);
  end

  always_comb begin
    logic [WAY_W-1:0]   found;
    logic [WAY_W-1:0]   split;
    logic               hit;
    logic [ENTRY_W-1:0] top;
    found = '0;
    // last match wins: nearest mru
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (match[i]) begin
        found = WAY_W'(i);
      end
    end
    hit   = |match;
    split = hit ? found : '0;
    if (hit) begin
      top = ent[found];
      if (is_write) begin
        top[DIRTY_B] = 1'b1;
      end
    end else begin
      top = {1'b1, is_write, tag};
    end
    for (int i = 0; i < NUM_WAYS - 1; i++) begin
      if (WAY_W'(i) < split) begin
        new_row[i*ENTRY_W +: ENTRY_W] = ent[i];
      end else begin
        new_row[i*ENTRY_W +: ENTRY_W] = ent[i+1];
      end
    end
    new_row[(NUM_WAYS-1)*ENTRY_W +: ENTRY_W] = top;
    res.hit        = hit;
    res.writeback  = !hit && ent[0][VALID_B] && ent[0][DIRTY_B];
    res.victim_tag = (!hit && ent[0][VALID_B]) ? victim_tag12 : '0;
  end

endmodule

FILE: rtl/lru_set_assoc_tag_store_unit.sv
// channel  dir  tdata fields (low bit up)                 tuser
// s_*      in   set_index[5:0], tag_value[17:6], pad       req_type
// m_*      out  hit[0], writeback[1], victim_tag[13:2], pad -
//
// an item goes through a set row read from the way memory, then lru update
// and write back of the whole row
// after reset a clearing pass writes every set row, no input
// a stalled result holds the lookup until the output register frees up
// the next item is taken while the previous result waits on m_tready
module lru_set_assoc_tag_store_unit #(
  parameter int NUM_WAYS = 8,
  parameter int NUM_SETS = 64,
  parameter int TAG_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lru_ts_pkg::S_TDATA_W-1:0] s_tdata,  // set_index, tag_value
  input  logic                             s_tuser,  // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lru_ts_pkg::M_TDATA_W-1:0] m_tdata   // hit, writeback, victim_tag
);
  import lru_ts_pkg::*;

  localparam int ENTRY_W = TAG_BITS + 2;
  localparam int ROW_W   = NUM_WAYS * ENTRY_W;
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

  state_t              state;
  logic [SET_W-1:0]    clr_idx;
  logic                req_write;
  logic [SET_W-1:0]    req_set;
  logic [TAG_BITS-1:0] req_tag;

  logic [SET_W-1:0]       set_map [SET_SPAN];
  logic [SET_INDEX_W-1:0] in_set;
  logic [TAG_VALUE_W-1:0] in_tag;
  logic [TAG_BITS-1:0]    in_tag_m;
  logic                   accept;
  logic                   out_free;
  logic                   mem_wr_en;
  logic [SET_W-1:0]       mem_wr_addr;
  logic [ROW_W-1:0]       mem_wr_data;
  logic [ROW_W-1:0]       rd_row;
  logic [ROW_W-1:0]       new_row;
  result_t                res;

  for (genvar g = 0; g < SET_SPAN; g++) begin : g_set_map
    localparam int unsigned MAPPED = g % NUM_SETS;
    assign set_map[g] = MAPPED[SET_W-1:0];
  end

  assign in_set = s_tdata[SET_INDEX_W-1:0];
  assign in_tag = s_tdata[SET_INDEX_W +: TAG_VALUE_W];

  if (TAG_BITS >= TAG_VALUE_W) begin : g_wide_tag
    assign in_tag_m = TAG_BITS'(in_tag);
  end else begin : g_narrow_tag
    assign in_tag_m = in_tag[TAG_BITS-1:0];
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign mem_wr_en   = (state == ST_CLEAR) || ((state == ST_LOOKUP) && out_free);
  assign mem_wr_addr = (state == ST_CLEAR) ? clr_idx : req_set;
  assign mem_wr_data = (state == ST_CLEAR) ? '0 : new_row;

  lru_ts_mem #(
    .DEPTH  (NUM_SETS),
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (set_map[in_set]),
    .rd_data (rd_row),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  lru_ts_update #(
    .NUM_WAYS (NUM_WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_update (
    .row      (rd_row),
    .is_write (req_write),
    .tag      (req_tag),
    .new_row  (new_row),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_LOOKUP) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= M_TDATA_W'(res);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_write <= (s_tuser == REQ_WRITE);
      req_set   <= set_map[in_set];
      req_tag   <= in_tag_m;
    end
  end

`ifndef SYNTHESIS
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken again right after an accept");

  a_result_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(mem_wr_en) && $past(state == ST_LOOKUP))
    else $error("result shown without a row write back");

  a_hit_no_victim: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[M_TDATA_W-1:1] == '0)
    else $error("hit carries a victim");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_wr_en)
    else $error("way memory written while idle");
`endif

endmodule
